// ===== rtl/fcwd_pkg.sv =====
`default_nettype none

package fcwd_pkg;

	localparam int CNT_W = 6;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;

	localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_PREV = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DIGITS,
		PH_BODY
	} line_phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} code_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic [1:0] status;
	} text_word_t;

	// one command per coded byte that yields results
	typedef struct packed {
		logic [CNT_W-1:0] copy_cnt;
		logic             emit_en;
		logic [7:0]       emit_byte;
		logic [1:0]       emit_st;
		logic             wr_en;
		logic [CNT_W-1:0] wr_addr;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/front_coded_word_decoder.sv =====
`default_nettype none

// Front-coded word list decoder. Coded bytes enter on code, plain word bytes leave on text,
// each word closed by 0x0A. The front end takes one coded byte per cycle whenever its
// four-entry command queue has room; digits, CR bytes, blank lines and dropped overlong
// bytes finish there without any output. While text_stall is low the back end gives one
// plain byte per cycle; a byte yielding k output words holds it until all k are issued,
// the copied prefix bursting from the word store RAM. A prefix longer than the previous
// word gives one status 2 word and the block then swallows all input until reset.
module front_coded_word_decoder #(
	parameter int MAX_WORD = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 code_valid,
	output logic                      code_stall,
	input  wire fcwd_pkg::code_word_t code,
	output logic                      text_valid,
	input  wire logic                 text_stall,
	output fcwd_pkg::text_word_t      text
);
	import fcwd_pkg::*;

	logic push;
	cmd_t cmd;
	logic q_full;
	logic q_empty;
	logic pop;
	cmd_t head;

	fcwd_front #(
		.MAX_WORD(MAX_WORD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.push       (push),
		.cmd        (cmd),
		.q_full     (q_full)
	);

	fcwd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	fcwd_back #(
		.MAX_WORD(MAX_WORD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

`default_nettype wire

// ===== rtl/fcwd_ram.sv =====
`default_nettype none

module fcwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcwd_queue.sv =====
`default_nettype none

module fcwd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fcwd_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output fcwd_pkg::cmd_t     head,
	output logic               empty
);
	import fcwd_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;

	logic do_push;
	logic do_pop;

	assign full    = (fill_q == (PW+1)'(DEPTH));
	assign empty   = (fill_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcwd_front.sv =====
`default_nettype none

module fcwd_front #(
	parameter int MAX_WORD = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               code_valid,
	output logic                    code_stall,
	input  wire fcwd_pkg::code_word_t code,
	output logic                    push,
	output fcwd_pkg::cmd_t          cmd,
	input  wire logic               q_full
);
	import fcwd_pkg::*;

	line_phase_t      phase_q, phase_d;
	logic [CNT_W-1:0] cc_q, cc_d;
	logic [CNT_W-1:0] wp_q, wp_d;
	logic [CNT_W-1:0] plen_q, plen_d;
	logic             trunc_q, trunc_d;
	logic             halted_q, halted_d;

	logic             accept;
	logic [7:0]       b;
	logic             ends_line;
	logic             is_digit;
	logic [3:0]       dig;
	logic [9:0]       acc;
	logic [CNT_W-1:0] cc_sat;
	logic             skip, dig_ev, blank, act, start;
	logic             pre_none, pre_err, pre_copy;
	logic [CNT_W-1:0] wp_eff;
	logic [1:0]       st_base;
	logic             do_nl, do_put, do_drop;

	assign accept     = code_valid && !code_stall;
	assign code_stall = q_full;

	always_comb begin
		b         = code.in_byte;
		ends_line = code.stream_end || (b == CH_LF);
		is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
		dig       = 4'(b - CH_ZERO);
		acc       = ({4'd0, cc_q} << 3) + ({4'd0, cc_q} << 1) + {6'd0, dig};
		cc_sat    = (acc > {4'd0, COUNT_MAX}) ? COUNT_MAX : acc[CNT_W-1:0];

		skip   = !accept || halted_q || (!code.stream_end && (b == CH_CR));
		dig_ev = !skip && !code.stream_end && is_digit && (phase_q != PH_BODY);
		blank  = !skip && !dig_ev && ends_line && (phase_q == PH_IDLE);
		act    = !skip && !dig_ev && !blank;
		start  = act && (phase_q != PH_BODY);

		pre_none = start && (cc_q != '0) && (plen_q == '0);
		pre_err  = start && (cc_q != '0) && (plen_q != '0) && (cc_q > plen_q);
		pre_copy = start && (cc_q != '0) && (plen_q != '0) && !(cc_q > plen_q);
		wp_eff   = pre_copy ? cc_q : wp_q;
		st_base  = pre_none ? ST_NO_PREV : ST_OK;

		do_nl   = act && !pre_err && ends_line;
		do_put  = act && !pre_err && !ends_line && (wp_eff < CNT_W'(MAX_WORD));
		do_drop = act && !pre_err && !ends_line && !(wp_eff < CNT_W'(MAX_WORD));
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		cc_d     = cc_q;
		wp_d     = wp_q;
		plen_d   = plen_q;
		trunc_d  = trunc_q;
		halted_d = halted_q;
		if (dig_ev) begin
			phase_d = PH_DIGITS;
			cc_d    = (phase_q == PH_IDLE) ? {2'd0, dig} : cc_sat;
		end
		if (pre_err) begin
			halted_d = 1'b1;
		end
		if (do_nl) begin
			phase_d = PH_IDLE;
			plen_d  = wp_eff;
			wp_d    = '0;
			trunc_d = 1'b0;
		end
		if (do_put) begin
			phase_d = PH_BODY;
			wp_d    = wp_eff + 1'b1;
		end
		if (do_drop) begin
			phase_d = PH_BODY;
			wp_d    = wp_eff;
			trunc_d = 1'b1;
		end
	end

	// command out
	always_comb begin
		cmd          = '0;
		cmd.copy_cnt = pre_copy ? cc_q : '0;
		push         = pre_err || pre_copy || do_nl || do_put;
		if (pre_err) begin
			cmd.emit_en   = 1'b1;
			cmd.emit_byte = 8'd0;
			cmd.emit_st   = ST_SHORT;
		end
		if (do_nl) begin
			cmd.emit_en   = 1'b1;
			cmd.emit_byte = CH_LF;
			cmd.emit_st   = trunc_q ? ST_TRUNC : st_base;
		end
		if (do_put) begin
			cmd.emit_en   = 1'b1;
			cmd.emit_byte = b;
			cmd.emit_st   = st_base;
			cmd.wr_en     = 1'b1;
			cmd.wr_addr   = wp_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cc_q     <= '0;
			wp_q     <= '0;
			plen_q   <= '0;
			trunc_q  <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cc_q     <= cc_d;
			wp_q     <= wp_d;
			plen_q   <= plen_d;
			trunc_q  <= trunc_d;
			halted_q <= halted_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fcwd_back.sv =====
`default_nettype none

module fcwd_back #(
	parameter int MAX_WORD = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fcwd_pkg::cmd_t     head,
	input  wire logic               q_empty,
	output logic                    pop,
	output logic                    text_valid,
	input  wire logic               text_stall,
	output fcwd_pkg::text_word_t    text
);
	import fcwd_pkg::*;

	localparam int AW = $clog2(MAX_WORD);

	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_inc;

	logic       vld_s1;
	logic       ram_s1;
	logic [7:0] byte_s1;
	logic [1:0] st_s1;
	logic       last_s1;

	logic       out_vld_q;
	text_word_t out_q;

	logic       out_free;
	logic       s1_ready;
	logic       issue;
	logic       copying;
	logic       copy_end;
	logic       re;
	logic       we;
	logic [7:0] rdata;

	assign out_free = !out_vld_q || !text_stall;
	assign s1_ready = !vld_s1 || out_free;
	assign issue    = !q_empty && s1_ready;
	assign copying  = idx_q < head.copy_cnt;
	assign idx_inc  = idx_q + 1'b1;
	assign copy_end = copying && (idx_inc == head.copy_cnt);
	assign re       = issue && copying;
	assign we       = issue && !copying && head.wr_en;
	assign pop      = issue && (!copying || (copy_end && !head.emit_en));

	assign text_valid = out_vld_q;
	assign text       = out_q;

	fcwd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WORD)
	) u_word_ram (
		.clk   (clk),
		.we    (we),
		.waddr (head.wr_addr[AW-1:0]),
		.wdata (head.emit_byte),
		.re    (re),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= pop ? '0 : idx_inc;
			end
			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (out_free) begin
				vld_s1 <= 1'b0;
			end
			if (out_free) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ram_s1  <= copying;
			byte_s1 <= head.emit_byte;
			st_s1   <= copying ? ST_OK : head.emit_st;
			last_s1 <= !copying || (copy_end && !head.emit_en);
		end
		if (out_free && vld_s1) begin
			out_q.out_byte <= ram_s1 ? rdata : byte_s1;
			out_q.run_last <= last_s1;
			out_q.status   <= st_s1;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/front_coded_word_decoder_checker.sv =====
`timescale 1ns / 1ps

module front_coded_word_decoder_checker #(
	parameter int MAX_WORD = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 code_valid,
	input  logic                 code_stall,
	input  fcwd_pkg::code_word_t code,
	input  logic                 text_valid,
	input  logic                 text_stall,
	input  fcwd_pkg::text_word_t text,
	output int                   fail_count,
	output int                   pending,
	output int                   words_in,
	output int                   words_out,
	output logic [3:0]           status_seen
);

	import fcwd_pkg::*;

	localparam int MEM_AW = $clog2(MAX_WORD);

	logic [7:0]       word_mem [MAX_WORD];
	logic [CNT_W-1:0] last_len;
	logic [CNT_W-1:0] prefix_cnt;
	logic [CNT_W-1:0] wr_pos;
	line_phase_t      phase;
	logic             trunc;
	logic             stopped;
	text_word_t       plain_due [$];
	text_word_t       want;
	int               errs;
	int               n_in;
	int               n_out;
	logic [3:0]       seen;

	// expand one coded word into the plain text words it yields
	task automatic decode_code_word(input code_word_t w);
		logic [7:0]   b;
		logic         is_digit;
		logic         eol;
		logic [1:0]   st;
		int           v;
		int           i;
		text_word_t   burst [$];
		b = w.in_byte;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		eol = w.stream_end || (b == CH_LF);
		st = ST_OK;
		if (stopped || (!w.stream_end && b == CH_CR))
			return;
		if (!w.stream_end && is_digit && phase == PH_IDLE) begin
			prefix_cnt = CNT_W'(b - CH_ZERO);
			phase = PH_DIGITS;
			return;
		end
		if (!w.stream_end && is_digit && phase == PH_DIGITS) begin
			v = int'(prefix_cnt) * 10 + int'(b - CH_ZERO);
			prefix_cnt = (v > int'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(v);
			return;
		end
		if (eol && phase == PH_IDLE)
			return;
		if (phase != PH_BODY) begin
			if (prefix_cnt != 0) begin
				if (last_len == 0) begin
					st = ST_NO_PREV;
				end else if (prefix_cnt > last_len) begin
					stopped = 1'b1;
					plain_due.push_back('{out_byte: 8'h00, run_last: 1'b1, status: ST_SHORT});
					return;
				end else begin
					for (i = 0; i < int'(prefix_cnt); i++)
						burst.push_back('{out_byte: word_mem[i[MEM_AW-1:0]], run_last: 1'b0,
							status: st});
					wr_pos = prefix_cnt;
				end
			end
			phase = PH_BODY;
		end
		if (eol) begin
			burst.push_back('{out_byte: CH_LF, run_last: 1'b0,
				status: trunc ? ST_TRUNC : st});
			last_len = wr_pos;
			wr_pos = '0;
			trunc = 1'b0;
			phase = PH_IDLE;
		end else if (int'(wr_pos) < MAX_WORD) begin
			word_mem[wr_pos[MEM_AW-1:0]] = b;
			wr_pos = wr_pos + 1'b1;
			burst.push_back('{out_byte: b, run_last: 1'b0, status: st});
		end else begin
			trunc = 1'b1;
		end
		for (i = 0; i < burst.size(); i++) begin
			want = burst[i];
			want.run_last = (i == burst.size() - 1);
			plain_due.push_back(want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mem = '{default: 8'h00};
			last_len = '0;
			prefix_cnt = '0;
			wr_pos = '0;
			phase = PH_IDLE;
			trunc = 1'b0;
			stopped = 1'b0;
			plain_due.delete();
			errs = 0;
			n_in = 0;
			n_out = 0;
			seen = '0;
		end else begin
			if (code_valid && !code_stall) begin
				decode_code_word(code);
				n_in++;
			end
			if (text_valid && !text_stall) begin
				n_out++;
				seen[text.status] = 1'b1;
				if (plain_due.size() == 0) begin
					errs++;
					if (errs <= 100)
						$error("unexpected text word: out_byte %02h run_last %0b status %0d",
							text.out_byte, text.run_last, text.status);
				end else begin
					want = plain_due.pop_front();
					if (text.out_byte !== want.out_byte) begin
						errs++;
						if (errs <= 100)
							$error("out_byte: expected %02h, got %02h",
								want.out_byte, text.out_byte);
					end
					if (text.run_last !== want.run_last) begin
						errs++;
						if (errs <= 100)
							$error("run_last: expected %0b, got %0b",
								want.run_last, text.run_last);
					end
					if (text.status !== want.status) begin
						errs++;
						if (errs <= 100)
							$error("status: expected %0d, got %0d",
								want.status, text.status);
					end
				end
			end
		end
		fail_count <= errs;
		pending <= plain_due.size();
		words_in <= n_in;
		words_out <= n_out;
		status_seen <= seen;
	end

endmodule

// ===== tb/sv/front_coded_word_decoder_tb.sv =====
`timescale 1ns / 1ps

module front_coded_word_decoder_tb;

	import fcwd_pkg::*;

	localparam int MAX_WORD    = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       code_valid = 1'b0;
	logic       code_stall;
	code_word_t code = '0;
	logic       text_valid;
	logic       text_stall = 1'b0;
	text_word_t text;

	int         fail_count;
	int         pending;
	int         words_in;
	int         words_out;
	logic [3:0] status_seen;

	int               gap_pct = 8;
	int               quiet_cycles = 0;
	int               n_items = 0;
	int               n_lines = 0;
	bit               held = 1'b0;
	// lengths only, to keep prefixes legal until the deliberate halt
	logic [CNT_W-1:0] stim_len;
	logic [CNT_W-1:0] stim_cnt;

	front_coded_word_decoder #(
		.MAX_WORD(MAX_WORD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text)
	);

	front_coded_word_decoder_checker #(
		.MAX_WORD(MAX_WORD)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text),
		.fail_count(fail_count),
		.pending(pending),
		.words_in(words_in),
		.words_out(words_out),
		.status_seen(status_seen)
	);

	always #10 clk = ~clk;

	task automatic send_code(input logic [7:0] b, input logic e);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code <= '{in_byte: b, stream_end: e};
		n_items++;
		@(posedge clk);
		while (code_stall)
			@(posedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_code(s[i], 1'b0);
	endtask

	task automatic send_line(input string s);
		send_str(s);
		send_code(CH_LF, 1'b0);
	endtask

	task automatic random_line();
		int         kind;
		int         cnt;
		int         nbody;
		int         len;
		int         i;
		bit         digits;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		if (kind < 3) begin
			send_code(CH_LF, 1'b0);
			return;
		end
		if (kind < 5) begin
			send_code(CH_CR, 1'b0);
			send_code(CH_LF, 1'b0);
			return;
		end
		if (kind < 7) begin
			send_code(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		digits = ($urandom_range(0, 9) < 7) || (stim_cnt > stim_len);
		if (digits) begin
			cnt = $urandom_range(0, stim_len);
			if ($urandom_range(0, 9) == 0)
				send_code(CH_ZERO, 1'b0);
			if (cnt >= 10)
				send_code(CH_ZERO + 8'(cnt / 10), 1'b0);
			send_code(CH_ZERO + 8'(cnt % 10), 1'b0);
			stim_cnt = CNT_W'(cnt);
		end
		nbody = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
		len = (stim_cnt != 0 && stim_len != 0) ? int'(stim_cnt) : 0;
		for (i = 0; i < nbody; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i == 0) begin
				while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_LF || b == CH_CR)
					b = 8'($urandom_range(0, 255));
			end else if (b == CH_LF) begin
				b = 8'($urandom_range(0, 9));
			end
			send_code(b, 1'b0);
			if (b != CH_CR)
				len++;
		end
		if ($urandom_range(0, 99) < 15)
			send_code(8'($urandom_range(0, 255)), 1'b1);
		else
			send_code(CH_LF, 1'b0);
		if (digits || nbody != 0)
			stim_len = CNT_W'((len > MAX_WORD) ? MAX_WORD : len);
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_out >= 60) begin
				held = 1'b1;
				text_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			text_stall <= (gap_pct != 0) && ($urandom_range(0, 99) < gap_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (code_valid && !code_stall) || (text_valid && !text_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("front_coded_word_decoder_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// prefix with no previous word, CR and blank lines, digits-only line,
		// kept count, extreme bytes, stream end on body, blank and digit lines
		send_line("2hi");
		send_code(CH_CR, 1'b0);
		send_code(CH_LF, 1'b0);
		send_code(CH_LF, 1'b0);
		send_line("1");
		send_str("a");
		send_code(CH_CR, 1'b0);
		send_line("b");
		send_code(CH_ZERO, 1'b0);
		send_code(8'h00, 1'b0);
		send_code(8'hFF, 1'b0);
		send_code(8'hA5, 1'b1);
		send_code(8'h5A, 1'b1);
		send_str("02");
		send_code(8'h00, 1'b1);
		stim_len = 2;
		stim_cnt = 2;

		while (n_items < 350) begin
			gap_pct = (n_lines >= 20 && n_lines < 40) ? 0 : 8;
			random_line();
			n_lines++;
		end
		gap_pct = 8;

		// saturating count longer than the previous word halts the block
		send_line("0ok");
		send_line("9999z");
		send_line("ab");
		send_code(8'h41, 1'b1);
		code_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);

		$display("covered %0d coded words, %0d text words, %0d random lines",
			words_in, words_out, n_lines);
		$display("statuses seen (trunc/short/no-prev/ok): %b", status_seen);
		if (fail_count == 0 && pending == 0)
			$display("front_coded_word_decoder_tb: clean");
		else
			$display("front_coded_word_decoder_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fcwd_pkg.sv
rtl/fcwd_ram.sv
rtl/fcwd_queue.sv
rtl/fcwd_front.sv
rtl/fcwd_back.sv
rtl/front_coded_word_decoder.sv
tb/sv/front_coded_word_decoder_checker.sv
tb/sv/front_coded_word_decoder_tb.sv
